FILE: design/ps2mpt_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Field widths, register indexes, reset bounds and packet layout constants
// shared by the packet tracker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

   // coordinate width default for bounds and positions
   localparam int COORD_BITS_DEFAULT = 16;

   // stream field widths
   localparam int BYTE_BITS     = 8;
   localparam int DELTA_BITS    = 9;
   localparam int WHEEL_BITS    = 8;
   localparam int BUTTON_BITS   = 3;
   localparam int CURSOR_BITS   = 16;
   localparam int RSP_DATA_BITS = 64;

   // result word layout, lowest field first
   localparam int DX_LSB     = 0;
   localparam int DY_LSB     = DX_LSB + DELTA_BITS;
   localparam int WHEEL_LSB  = DY_LSB + DELTA_BITS;
   localparam int BUTTON_LSB = WHEEL_LSB + WHEEL_BITS;
   localparam int CX_LSB     = BUTTON_LSB + BUTTON_BITS;
   localparam int CY_LSB     = CX_LSB + CURSOR_BITS;
   localparam int RSP_USED   = CY_LSB + CURSOR_BITS;

   // header byte bits
   localparam int SIGN_X_BIT = 4;
   localparam int SIGN_Y_BIT = 5;

   // reset bounds
   localparam int MIN_X_RESET = 0;
   localparam int MIN_Y_RESET = 0;
   localparam int MAX_X_RESET = 1024;
   localparam int MAX_Y_RESET = 768;

   // byte counter
   localparam int POS_BITS = 2;
   localparam logic [POS_BITS-1:0] POS_FIRST      = 2'd0;
   localparam logic [POS_BITS-1:0] POS_LAST_PLAIN = 2'd2;
   localparam logic [POS_BITS-1:0] POS_LAST_WHEEL = 2'd3;
   localparam int PKT_STORE_DEPTH = 3;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MIN_X      = 3'd0,
      REG_MIN_Y      = 3'd1,
      REG_MAX_X      = 3'd2,
      REG_MAX_Y      = 3'd3,
      REG_WHEEL_MODE = 3'd4
   } csr_index_type;

endpackage

FILE: design/ps2_mouse_packet_tracker.sv
// A byte accepted is held in the input register, and the result of a
// completing byte is then registered in the result register.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or being taken.
// Reset: byte counter and cursor cleared, bounds to 0..1024 and 0..768,
// wheel mode off. Packet byte store is not reset.
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Collects mouse bytes into 3- or 4-byte packets, decodes deltas, wheel and
// buttons, and tracks a clamped cursor position inside programmable bounds.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
   parameter int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request stream
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [ps2mpt_pkg::BYTE_BITS-1:0]        req_tdata,   // [7:0] data_byte
   input  logic                                    req_tuser,   // [0] aux_flag
   // response stream
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [8:0] delta_x, [17:9] delta_y, [25:18] wheel_delta, [28:26] button_bits,
   // [44:29] cursor_x, [60:45] cursor_y, [63:61] zero
   output logic [ps2mpt_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // configuration write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ps2mpt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [COORD_BITS-1:0]                   csr_wdata
);
   import ps2mpt_pkg::*;

   // input register
   logic                    s1_valid_ff, s1_valid_in;
   logic [BYTE_BITS-1:0]    s1_data_ff;

   // packet state
   logic [POS_BITS-1:0]     byte_pos_ff, byte_pos_in;
   logic [BYTE_BITS-1:0]    pkt_ff [PKT_STORE_DEPTH];
   logic signed [COORD_BITS-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;

   // configuration
   logic signed [COORD_BITS-1:0] min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic signed [COORD_BITS-1:0] max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic                    wheel_mode_ff, wheel_mode_in;
   logic                    csr_write, recenter;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // datapath
   logic                    advance, fire, pkt_end, complete;
   logic [BYTE_BITS-1:0]    hdr_byte, y_byte, wheel_byte;
   logic signed [DELTA_BITS-1:0] dx, dy;
   logic signed [WHEEL_BITS-1:0] dz;
   logic signed [COORD_BITS:0]   step_x, step_y, clamp_x, clamp_y;
   logic signed [COORD_BITS:0]   sum_x, sum_y, adj_x, adj_y;

   // handshakes
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign fire       = s1_valid_ff && advance;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a packet ends on the fourth byte, or on the third without wheel mode
   assign pkt_end  = (byte_pos_ff == POS_LAST_WHEEL) ||
                     ((byte_pos_ff == POS_LAST_PLAIN) && !wheel_mode_ff);
   assign complete = fire && pkt_end;

   // assemble packet bytes; completion only happens at the third or fourth byte
   assign hdr_byte   = pkt_ff[0];
   assign y_byte     = (byte_pos_ff == POS_LAST_PLAIN) ? s1_data_ff : pkt_ff[2];
   assign wheel_byte = (byte_pos_ff == POS_LAST_WHEEL) ? s1_data_ff : '0;

   // decode deltas
   assign dx = $signed({hdr_byte[SIGN_X_BIT], pkt_ff[1]});
   assign dy = $signed({hdr_byte[SIGN_Y_BIT], y_byte});
   assign dz = wheel_mode_ff ? $signed(wheel_byte) : '0;

   // move and clamp: minimum first, then maximum
   assign step_x = (COORD_BITS+1)'(pos_x_ff) - (COORD_BITS+1)'(dx);
   assign step_y = (COORD_BITS+1)'(pos_y_ff) + (COORD_BITS+1)'(dy);

   always_comb begin
      clamp_x = step_x;
      if (clamp_x < (COORD_BITS+1)'(min_x_ff)) begin
         clamp_x = (COORD_BITS+1)'(min_x_ff);
      end
      if (clamp_x > (COORD_BITS+1)'(max_x_ff)) begin
         clamp_x = (COORD_BITS+1)'(max_x_ff);
      end
      clamp_y = step_y;
      if (clamp_y < (COORD_BITS+1)'(min_y_ff)) begin
         clamp_y = (COORD_BITS+1)'(min_y_ff);
      end
      if (clamp_y > (COORD_BITS+1)'(max_y_ff)) begin
         clamp_y = (COORD_BITS+1)'(max_y_ff);
      end
   end

   // configuration write decode
   always_comb begin
      min_x_in      = min_x_ff;
      min_y_in      = min_y_ff;
      max_x_in      = max_x_ff;
      max_y_in      = max_y_ff;
      wheel_mode_in = wheel_mode_ff;
      recenter      = 1'b0;
      if (csr_write) begin
         case (csr_index)
            REG_MIN_X: begin
               min_x_in = csr_wdata;
               recenter = 1'b1;
            end
            REG_MIN_Y: begin
               min_y_in = csr_wdata;
               recenter = 1'b1;
            end
            REG_MAX_X: begin
               max_x_in = csr_wdata;
               recenter = 1'b1;
            end
            REG_MAX_Y: begin
               max_y_in = csr_wdata;
               recenter = 1'b1;
            end
            REG_WHEEL_MODE: begin
               wheel_mode_in = csr_wdata[0];
            end
            default: begin
               recenter = 1'b0;
            end
         endcase
      end
   end

   // centre of the new bounds, halved toward zero
   assign sum_x = (COORD_BITS+1)'(min_x_in) + (COORD_BITS+1)'(max_x_in);
   assign sum_y = (COORD_BITS+1)'(min_y_in) + (COORD_BITS+1)'(max_y_in);
   assign adj_x = sum_x + $signed({{COORD_BITS{1'b0}}, sum_x[COORD_BITS]});
   assign adj_y = sum_y + $signed({{COORD_BITS{1'b0}}, sum_y[COORD_BITS]});

   // next state of counter, cursor and input register
   always_comb begin
      byte_pos_in = byte_pos_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      if (fire) begin
         byte_pos_in = pkt_end ? POS_FIRST : byte_pos_ff + 1'b1;
      end
      if (complete) begin
         pos_x_in = clamp_x[COORD_BITS-1:0];
         pos_y_in = clamp_y[COORD_BITS-1:0];
      end
      if (recenter) begin
         pos_x_in = adj_x[COORD_BITS:1];
         pos_y_in = adj_y[COORD_BITS:1];
      end

      if (req_tvalid && req_tready) begin
         s1_valid_in = req_tuser;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (complete) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // pack the result word
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[DX_LSB +: DELTA_BITS]      = dx;
      rsp_data_in[DY_LSB +: DELTA_BITS]      = dy;
      rsp_data_in[WHEEL_LSB +: WHEEL_BITS]   = dz;
      rsp_data_in[BUTTON_LSB +: BUTTON_BITS] = hdr_byte[BUTTON_BITS-1:0];
      rsp_data_in[CX_LSB +: CURSOR_BITS]     = CURSOR_BITS'($unsigned(clamp_x[COORD_BITS-1:0]));
      rsp_data_in[CY_LSB +: CURSOR_BITS]     = CURSOR_BITS'($unsigned(clamp_y[COORD_BITS-1:0]));
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byte_pos_ff   <= POS_FIRST;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         min_x_ff      <= COORD_BITS'(MIN_X_RESET);
         min_y_ff      <= COORD_BITS'(MIN_Y_RESET);
         max_x_ff      <= COORD_BITS'(MAX_X_RESET);
         max_y_ff      <= COORD_BITS'(MAX_Y_RESET);
         wheel_mode_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         byte_pos_ff   <= byte_pos_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         min_x_ff      <= min_x_in;
         min_y_ff      <= min_y_in;
         max_x_ff      <= max_x_in;
         max_y_ff      <= max_y_in;
         wheel_mode_ff <= wheel_mode_in;
      end
   end

   // payload registers: input byte, packet store, result word
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata;
      end
      if (fire && !pkt_end) begin
         pkt_ff[byte_pos_ff] <= s1_data_ff;
      end
      if (complete) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // the counter restarts after every completed packet
   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      complete && !recenter |=> byte_pos_ff == POS_FIRST)
      else $error("byte counter did not restart after a packet");

   // cursor stays inside ordered bounds
   a_x_in_bounds: assert property (@(posedge clock) disable iff (reset)
      min_x_ff <= max_x_ff |-> (pos_x_ff >= min_x_ff) && (pos_x_ff <= max_x_ff))
      else $error("cursor x outside its bounds");

   a_y_in_bounds: assert property (@(posedge clock) disable iff (reset)
      min_y_ff <= max_y_ff |-> (pos_y_ff >= min_y_ff) && (pos_y_ff <= max_y_ff))
      else $error("cursor y outside its bounds");

endmodule

FILE: bench/tb_ps2_mouse_packet_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker testbench
// Streams mouse bytes through the tracker with random gaps and stalls on both
// sides, reprograms the cursor bounds and the wheel mode between bursts, and
// checks every report word against a cycle-free model of packet assembly,
// delta decoding and clamped cursor tracking kept inside the bench.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_tracker;
   import ps2mpt_pkg::*;

   localparam int IDLE_PCT     = 8;
   localparam int RANDOM_ITEMS = 450;
   localparam int DRAIN_CYCLES = 8;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int MAX_REPORTED = 10;
   // indexes beyond the register map, which the tracker must ignore
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [DELTA_BITS-1:0]  delta_x;
      logic [DELTA_BITS-1:0]  delta_y;
      logic [WHEEL_BITS-1:0]  wheel;
      logic [BUTTON_BITS-1:0] buttons;
      logic [CURSOR_BITS-1:0] cursor_x;
      logic [CURSOR_BITS-1:0] cursor_y;
   } mouse_report_type;

   typedef enum logic {STEP_BYTE, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type             kind;
      logic [CSR_INDEX_BITS-1:0] reg_idx;
      logic [15:0]               reg_val;
      logic                      aux;
      logic [BYTE_BITS-1:0]      data;
      logic                      has_want;
      mouse_report_type          want;
   } step_row_type;

   // directed steps: extremes, ignored bytes, wheel packets, mode change with
   // three bytes held, inverted bounds, truncating recentre, spare index
   localparam int N_STEPS = 35;
   localparam step_row_type DIRECTED_STEPS [N_STEPS] = '{
      '{STEP_BYTE, '0, '0, 1'b0, 8'hFF, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h07, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'hFF, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'hFF, 1'b1,
        '{9'h0FF, 9'h0FF, 8'h00, 3'h7, 16'h0000, 16'h00FF}},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h38, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h00, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b0, 8'h5A, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h00, 1'b1,
        '{9'h100, 9'h100, 8'h00, 3'h0, 16'h0100, 16'h0000}},
      '{STEP_CSR, REG_WHEEL_MODE, 16'h0001, 1'b0, 8'h00, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h08, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h01, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h00, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h80, 1'b1,
        '{9'h001, 9'h000, 8'h80, 3'h0, 16'h00FF, 16'h0000}},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h0C, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h00, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h02, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h7F, 1'b1,
        '{9'h000, 9'h002, 8'h7F, 3'h4, 16'h00FF, 16'h0002}},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h09, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h05, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h03, 1'b0, '0},
      '{STEP_CSR, REG_WHEEL_MODE, 16'h0000, 1'b0, 8'h00, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'hAA, 1'b0, '0},
      '{STEP_CSR, REG_MIN_X, 16'd100, 1'b0, 8'h00, 1'b0, '0},
      '{STEP_CSR, REG_MAX_X, 16'd50, 1'b0, 8'h00, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h08, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h00, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h00, 1'b0, '0},
      '{STEP_CSR, REG_MIN_X, 16'h8000, 1'b0, 8'h00, 1'b0, '0},
      '{STEP_CSR, REG_MAX_X, 16'h7FFF, 1'b0, 8'h00, 1'b0, '0},
      '{STEP_CSR, REG_MIN_Y, 16'h8000, 1'b0, 8'h00, 1'b0, '0},
      '{STEP_CSR, REG_MAX_Y, 16'h8001, 1'b0, 8'h00, 1'b0, '0},
      '{STEP_CSR, REG_SPARE_HI, 16'h0000, 1'b0, 8'h00, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h28, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h00, 1'b0, '0},
      '{STEP_BYTE, '0, '0, 1'b1, 8'h00, 1'b1,
        '{9'h000, 9'h100, 8'h00, 3'h0, 16'h0000, 16'h8000}}
   };

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [BYTE_BITS-1:0]      req_tdata  = '0;     // [7:0] data_byte
   logic                      req_tuser  = 1'b0;   // [0] aux_flag
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // [8:0] delta_x, [17:9] delta_y, [25:18] wheel_delta, [28:26] button_bits,
   // [44:29] cursor_x, [60:45] cursor_y, [63:61] zero
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [15:0]               csr_wdata  = '0;

   // tracker model state
   logic signed [15:0] lo_x = 16'(MIN_X_RESET);
   logic signed [15:0] lo_y = 16'(MIN_Y_RESET);
   logic signed [15:0] hi_x = 16'(MAX_X_RESET);
   logic signed [15:0] hi_y = 16'(MAX_Y_RESET);
   logic               wheel_on  = 1'b0;
   logic [1:0]         byte_slot = POS_FIRST;
   logic [7:0]         held_bytes [PKT_STORE_DEPTH] = '{8'h00, 8'h00, 8'h00};
   logic signed [15:0] cur_x = '0;
   logic signed [15:0] cur_y = '0;

   mouse_report_type pending_reports [$];
   int unsigned   faults      = 0;
   int unsigned   mouse_bytes = 0;
   bit            calm        = 1'b0;

   ps2_mouse_packet_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // advance the model by one accepted byte; done is set when a packet closes
   task automatic track_mouse_byte(input logic aux, input logic [7:0] data,
                                   output bit done, output mouse_report_type rep);
      int                slots;
      logic [7:0]        hdr, mx, my, mz;
      logic signed [8:0] dx, dy;
      int                nx, ny;
      done = 1'b0;
      rep  = '0;
      if (!aux)
         return;
      slots = wheel_on ? 4 : 3;
      if (int'(byte_slot) + 1 < slots) begin
         held_bytes[byte_slot] = data;
         byte_slot = byte_slot + 2'd1;
         return;
      end
      // the closing byte stands in for its own slot; a fourth byte is dropped
      // once wheel mode has been switched off
      hdr = (byte_slot == 2'd0) ? data : held_bytes[0];
      mx  = (byte_slot == 2'd1) ? data : held_bytes[1];
      my  = (byte_slot == 2'd2) ? data : held_bytes[2];
      mz  = (byte_slot == POS_LAST_WHEEL) ? data : 8'h00;
      byte_slot = POS_FIRST;
      dx = {hdr[SIGN_X_BIT], mx};
      dy = {hdr[SIGN_Y_BIT], my};
      // clamp to the minimum first, so inverted bounds end at the maximum
      nx = int'(cur_x) - int'(dx);
      if (nx < int'(lo_x)) nx = int'(lo_x);
      if (nx > int'(hi_x)) nx = int'(hi_x);
      ny = int'(cur_y) + int'(dy);
      if (ny < int'(lo_y)) ny = int'(lo_y);
      if (ny > int'(hi_y)) ny = int'(hi_y);
      cur_x = 16'(nx);
      cur_y = 16'(ny);
      rep.delta_x  = dx;
      rep.delta_y  = dy;
      rep.wheel    = wheel_on ? mz : 8'h00;
      rep.buttons  = hdr[BUTTON_BITS-1:0];
      rep.cursor_x = cur_x;
      rep.cursor_y = cur_y;
      done = 1'b1;
   endtask

   // mirror a register write; any bound write recentres both axes
   task automatic apply_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [15:0] val);
      case (idx)
         REG_MIN_X:      lo_x = val;
         REG_MIN_Y:      lo_y = val;
         REG_MAX_X:      hi_x = val;
         REG_MAX_Y:      hi_y = val;
         REG_WHEEL_MODE: wheel_on = val[0];
         default: ;
      endcase
      if (idx <= REG_MAX_Y) begin
         cur_x = 16'((int'(lo_x) + int'(hi_x)) / 2);
         cur_y = 16'((int'(lo_y) + int'(hi_y)) / 2);
      end
   endtask

   function automatic string describe(mouse_report_type r);
      return $sformatf("dx=%0d dy=%0d wheel=%0d buttons=%0d x=%0d y=%0d",
                       $signed(r.delta_x), $signed(r.delta_y), $signed(r.wheel),
                       r.buttons, $signed(r.cursor_x), $signed(r.cursor_y));
   endfunction

   function automatic void note_fault(string msg);
      faults++;
      if (faults <= MAX_REPORTED)
         $display("mismatch: %s", msg);
   endfunction

   // movement bytes lean towards the sign and magnitude extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   // bound pairs: ordinary windows, full range, raw, inverted, tight, edges
   function automatic void pick_bounds(output logic [15:0] lo, output logic [15:0] hi);
      int base;
      base = int'($urandom_range(1200)) - 600;
      case ($urandom_range(5))
         0: begin
            lo = 16'(base);
            hi = 16'(base + int'($urandom_range(1200)));
         end
         1: begin
            lo = 16'h8000;
            hi = 16'h7FFF;
         end
         2: begin
            lo = 16'($urandom);
            hi = 16'($urandom);
         end
         3: begin
            lo = 16'(base);
            hi = 16'(base - int'($urandom_range(300, 1)));
         end
         4: begin
            lo = 16'(base);
            hi = 16'(base + int'($urandom_range(10)));
         end
         default: begin
            if ($urandom_range(1)) begin
               lo = 16'h8000;
               hi = 16'(-32768 + int'($urandom_range(400)));
            end else begin
               hi = 16'h7FFF;
               lo = 16'(32767 - int'($urandom_range(400)));
            end
         end
      endcase
   endfunction

   // offer one byte word and hold it until taken, then log what it should yield
   task automatic send_byte(input logic aux, input logic [7:0] data,
                            input bit has_want, input mouse_report_type want);
      bit               done;
      mouse_report_type rep;
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= aux;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      track_mouse_byte(aux, data, done, rep);
      if (done || has_want)
         pending_reports.push_back(has_want ? want : rep);
      mouse_bytes++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop the byte stream and wait for the tracker to fall quiet
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: random stalls, none during the calm stretch
   always @(negedge clock)
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

   // compare each report word with the oldest pending one
   always @(posedge clock) begin : report_check
      mouse_report_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.delta_x  = rsp_tdata[DX_LSB +: DELTA_BITS];
         got.delta_y  = rsp_tdata[DY_LSB +: DELTA_BITS];
         got.wheel    = rsp_tdata[WHEEL_LSB +: WHEEL_BITS];
         got.buttons  = rsp_tdata[BUTTON_LSB +: BUTTON_BITS];
         got.cursor_x = rsp_tdata[CX_LSB +: CURSOR_BITS];
         got.cursor_y = rsp_tdata[CY_LSB +: CURSOR_BITS];
         if (pending_reports.size() == 0) begin
            note_fault({"report with none pending: ", describe(got)});
         end else begin
            want = pending_reports.pop_front();
            if (got !== want)
               note_fault({"expected ", describe(want), " got ", describe(got)});
         end
      end
   end

   initial begin : stimulus
      logic [15:0]               lo, hi;
      logic [CSR_INDEX_BITS-1:0] lo_reg, hi_reg;
      int                        slots, cut;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (DIRECTED_STEPS[r]) begin
         if (DIRECTED_STEPS[r].kind == STEP_CSR) begin
            settle_block();
            write_register(DIRECTED_STEPS[r].reg_idx, DIRECTED_STEPS[r].reg_val);
         end else begin
            send_byte(DIRECTED_STEPS[r].aux, DIRECTED_STEPS[r].data,
                      DIRECTED_STEPS[r].has_want, DIRECTED_STEPS[r].want);
         end
      end

      // random bursts of packets, each under freshly written settings
      while (mouse_bytes < RANDOM_ITEMS) begin
         settle_block();
         calm = (mouse_bytes >= 150 && mouse_bytes < 260);
         for (int ax = 0; ax < 2; ax++) begin
            lo_reg = ax ? REG_MIN_Y : REG_MIN_X;
            hi_reg = ax ? REG_MAX_Y : REG_MAX_X;
            if ($urandom_range(99) < 75) begin
               pick_bounds(lo, hi);
               if ($urandom_range(1)) begin
                  write_register(lo_reg, lo);
                  write_register(hi_reg, hi);
               end else begin
                  write_register(hi_reg, hi);
                  write_register(lo_reg, lo);
               end
            end
         end
         if ($urandom_range(1))
            write_register(REG_WHEEL_MODE, 16'($urandom));
         if ($urandom_range(9) == 0)
            write_register(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 16'($urandom));

         // mostly whole packets, some cut short, with stray non-mouse bytes
         repeat ($urandom_range(16, 3)) begin
            slots = wheel_on ? 4 : 3;
            cut = ($urandom_range(99) < 10) ? $urandom_range(slots - 1, 1) : slots;
            for (int b = 0; b < cut; b++) begin
               if ($urandom_range(99) < 6)
                  send_byte(1'b0, 8'($urandom), 1'b0, '0);
               send_byte(1'b1, (b == 0) ? 8'($urandom) : pick_byte(), 1'b0, '0);
            end
         end
         // leave a wheel packet three bytes in, ready for a mode change
         if (wheel_on && $urandom_range(3) == 0)
            repeat (3) send_byte(1'b1, pick_byte(), 1'b0, '0);
      end

      calm = 1'b0;
      settle_block();
      if (faults == 0 && pending_reports.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #TIMEOUT_NS;
      $display("simulation failed");
      $finish;
   end

endmodule
